// ===== rtl/bb3_pkg.sv =====
// Shared types, constants and small helper functions for the 3x3 box blur.
// Used by the top, lane and merge modules; depends on nothing else.
`default_nettype none

package bb3_pkg;

   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int PIX_W      = CH_W * NUM_CH;
   localparam int WIN_N      = 3;
   localparam int CELLS      = WIN_N * WIN_N;
   localparam int SUM_W      = 12;
   localparam int CNT_W      = 4;
   localparam int RECIP_W    = 20;

   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int WIDTH_FIELD_W  = 11;
   localparam int HEIGHT_FIELD_W = 13;
   localparam int RESET_DIM      = 1024;

   // result queue: items in flight between accept and the queue, two results each
   localparam int FIFO_DEPTH   = 16;
   localparam int FIFO_AW      = 4;
   localparam int PIPE_ITEMS   = 4;
   localparam int MAX_RESULTS  = 2;
   localparam int ACCEPT_LEVEL = FIFO_DEPTH - (PIPE_ITEMS + 1) * MAX_RESULTS;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // per-item control carried down the pipeline; bit i of row_ok is window row i,
   // bit j of col_ok is window column j
   typedef struct packed {
      logic       flush;
      logic       emit0;
      logic       emit1;
      logic       fend0;
      logic       last0;
      logic [2:0] row_ok;
      logic [2:0] col_ok0;
      logic [2:0] col_ok1;
   } ctrl_type;

   typedef struct packed {
      logic emit0;
      logic emit1;
      logic fend0;
      logic last0;
   } flags_type;

   typedef struct packed {
      logic             frame_end;
      logic             run_last;
      logic [PIX_W-1:0] pixel;
   } entry_type;

   function automatic logic [CELLS-1:0] cell_mask(input logic [2:0] row_ok,
                                                  input logic [2:0] col_ok);
      logic [CELLS-1:0] m;
      for (int i = 0; i < WIN_N; i++) begin
         for (int j = 0; j < WIN_N; j++) begin
            m[i*WIN_N + j] = row_ok[i] & col_ok[j];
         end
      end
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] mask_count(input logic [CELLS-1:0] m);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < CELLS; i++) begin
         n = n + CNT_W'(m[i]);
      end
      return n;
   endfunction

   // ceil(2^20 / (2*n)); exact floor division of numerators below 4600
   function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      unique case (n)
         4'd1:    r = 20'd524288;
         4'd2:    r = 20'd262144;
         4'd3:    r = 20'd174763;
         4'd4:    r = 20'd131072;
         4'd6:    r = 20'd87382;
         4'd9:    r = 20'd58255;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_aware.sv =====
// 3x3 box blur with edge-aware averaging over an RGB raster stream. The block
// takes one beat per clock while req_tready is high, and the output port moves
// one beat per clock while rsp_tready is high; an item that ends a row can yield
// two result beats. req_tready falls only while the result queue holds more
// than six beats, which covers every item already in the five-stage pipeline.
// Two line stores of MAX_WIDTH pixels, each with two read ports, feed a 3x3
// window; three channel lanes sum and divide, and a merge queue serializes the
// results. After the last pixel of a frame, send one flush beat per pixel of
// the last row. No clearing pass is needed after reset. A configuration write
// restarts the frame and must only be issued while the block is idle.
`default_nettype none

module box_blur_3x3_edge_aware #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [23:0]                    req_tdata,   // in_red, in_green, in_blue
   input  wire logic                           req_tuser,   // kind
   // result stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [23:0]                    rsp_tdata,   // out_red, out_green, out_blue
   output logic                                rsp_tuser,   // frame_end
   output logic                                rsp_tlast,   // run_last
   // register writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bb3_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [bb3_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RESET_W = (MAX_WIDTH  < bb3_pkg::RESET_DIM) ? MAX_WIDTH  : bb3_pkg::RESET_DIM;
   localparam int RESET_H = (MAX_HEIGHT < bb3_pkg::RESET_DIM) ? MAX_HEIGHT : bb3_pkg::RESET_DIM;
   localparam int PW = bb3_pkg::PIX_W;
   localparam int CH = bb3_pkg::CH_W;
   localparam int NC = bb3_pkg::NUM_CH;
   localparam int WN = bb3_pkg::WIN_N;
   localparam int NCELL = bb3_pkg::CELLS;

   // ---------------- configuration ----------------
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [bb3_pkg::WIDTH_FIELD_W-1:0]  wval;
   logic [bb3_pkg::HEIGHT_FIELD_W-1:0] hval;
   logic [WW-1:0] wclamp;
   logic [HW-1:0] hclamp;
   logic          csr_hit;

   assign csr_ready = 1'b1;
   assign wval = csr_wdata[bb3_pkg::WIDTH_FIELD_W-1:0];
   assign hval = csr_wdata[bb3_pkg::HEIGHT_FIELD_W-1:0];

   always_comb begin
      if (wval == '0) begin
         wclamp = WW'(1);
      end else if (int'(wval) > MAX_WIDTH) begin
         wclamp = WW'(MAX_WIDTH);
      end else begin
         wclamp = WW'(wval);
      end
      if (hval == '0) begin
         hclamp = HW'(1);
      end else if (int'(hval) > MAX_HEIGHT) begin
         hclamp = HW'(MAX_HEIGHT);
      end else begin
         hclamp = HW'(hval);
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      csr_hit   = 1'b0;
      if (csr_valid) begin
         if (csr_addr == bb3_pkg::CSR_FRAME_WIDTH) begin
            width_in = wclamp;
            csr_hit  = 1'b1;
         end else if (csr_addr == bb3_pkg::CSR_FRAME_HEIGHT) begin
            height_in = hclamp;
            csr_hit   = 1'b1;
         end
      end
   end

   // ---------------- stage A: accept, position, line store read ----------------
   logic [CW-1:0] col_ff, col_in, drain_ff, drain_in;
   logic [RW-1:0] row_ff, row_in;
   logic          draining_ff, draining_in;
   logic          acc, is_pix, is_fl, rowend, lastrow, fin;
   logic          r_ge1, r_ge2, c_ge1, c_ge2, h_ge2;
   logic [CW-1:0] rd_addr_a, rd_addr_b;
   bb3_pkg::ctrl_type ctrl_a;
   logic          accept_ok;

   assign req_tready = accept_ok;
   assign acc        = req_tvalid & req_tready;
   assign is_pix     = acc & (req_tuser == bb3_pkg::KIND_PIXEL) & ~draining_ff;
   assign is_fl      = acc & (req_tuser == bb3_pkg::KIND_FLUSH) & draining_ff;
   assign rowend     = (WW'(col_ff) + WW'(1)) >= width_ff;
   assign lastrow    = (HW'(row_ff) + HW'(1)) >= height_ff;
   assign fin        = (WW'(drain_ff) + WW'(1)) >= width_ff;
   assign r_ge1      = (row_ff != '0);
   assign r_ge2      = (row_ff > RW'(1));
   assign c_ge1      = (col_ff != '0);
   assign c_ge2      = (col_ff > CW'(1));
   assign h_ge2      = (height_ff > HW'(1));

   assign rd_addr_a = draining_ff ? drain_ff : col_ff;
   assign rd_addr_b = drain_ff + CW'(1);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      if (csr_hit) begin
         col_in      = '0;
         row_in      = '0;
         drain_in    = '0;
         draining_in = 1'b0;
      end else if (is_pix) begin
         if (rowend) begin
            col_in = '0;
            if (lastrow) begin
               draining_in = 1'b1;
               drain_in    = '0;
               row_in      = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else if (is_fl) begin
         if (fin) begin
            draining_in = 1'b0;
            drain_in    = '0;
            row_in      = '0;
            col_in      = '0;
         end else begin
            drain_in = drain_ff + CW'(1);
         end
      end
   end

   always_comb begin
      if (draining_ff) begin
         ctrl_a.flush   = 1'b1;
         ctrl_a.emit0   = 1'b1;
         ctrl_a.emit1   = 1'b0;
         ctrl_a.fend0   = fin;
         ctrl_a.last0   = 1'b1;
         ctrl_a.row_ok  = {1'b0, 1'b1, h_ge2};
         ctrl_a.col_ok0 = {~fin, 1'b1, (drain_ff != '0)};
         ctrl_a.col_ok1 = '0;
      end else begin
         ctrl_a.flush   = 1'b0;
         ctrl_a.emit0   = r_ge1 & c_ge1;
         ctrl_a.emit1   = r_ge1 & rowend;
         ctrl_a.fend0   = 1'b0;
         ctrl_a.last0   = ~rowend;
         ctrl_a.row_ok  = {1'b1, 1'b1, r_ge2};
         ctrl_a.col_ok0 = {1'b1, 1'b1, c_ge2};
         ctrl_a.col_ok1 = {1'b1, c_ge1, 1'b0};
      end
   end

   // ---------------- stage B: line store write, window shift ----------------
   logic              v_b_ff;
   bb3_pkg::ctrl_type ctrl_b_ff;
   logic [CW-1:0]     addr_b_ff;
   logic [PW-1:0]     px_b_ff;
   logic              fwd_a_ff, fwd_b_ff, fwd_a_in, fwd_b_in;
   logic [PW-1:0]     fwd_up_ff, fwd_mid_ff;
   logic              b_wr_en;
   logic [PW-1:0]     up_q_a, up_q_b, mid_q_a, mid_q_b;
   logic [PW-1:0]     up_a, up_b, mid_a, mid_b;
   logic [WN-1:0][WN-1:0][PW-1:0] win_ff, win_in;

   bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock     (clock),
      .wr_en     (b_wr_en),
      .wr_addr   (addr_b_ff),
      .wr_data   (mid_a),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (up_q_a),
      .rd_data_b (up_q_b)
   );

   bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock     (clock),
      .wr_en     (b_wr_en),
      .wr_addr   (addr_b_ff),
      .wr_data   (px_b_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (mid_q_a),
      .rd_data_b (mid_q_b)
   );

   assign b_wr_en = v_b_ff & ~ctrl_b_ff.flush;

   // bypass a write that lands in the same cycle as the read of that column
   assign fwd_a_in = b_wr_en & (addr_b_ff == rd_addr_a);
   assign fwd_b_in = b_wr_en & (addr_b_ff == rd_addr_b);

   assign up_a  = fwd_a_ff ? fwd_up_ff  : up_q_a;
   assign mid_a = fwd_a_ff ? fwd_mid_ff : mid_q_a;
   assign up_b  = fwd_b_ff ? fwd_up_ff  : up_q_b;
   assign mid_b = fwd_b_ff ? fwd_mid_ff : mid_q_b;

   always_comb begin
      win_in = win_ff;
      if (v_b_ff) begin
         for (int i = 0; i < WN; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[2][2] = px_b_ff;
         if (ctrl_b_ff.flush) begin
            // drain: columns d and d+1 of the last two rows
            win_in[0][1] = up_a;
            win_in[1][1] = mid_a;
            win_in[0][2] = up_b;
            win_in[1][2] = mid_b;
         end else begin
            win_in[0][2] = up_a;
            win_in[1][2] = mid_a;
         end
      end
   end

   // ---------------- stages C, D, E: lanes and merge ----------------
   logic              v_c_ff, v_d_ff, v_e_ff;
   bb3_pkg::ctrl_type ctrl_c_ff, ctrl_d_ff, ctrl_e_ff;
   logic [NCELL-1:0]  mask0_c, mask1_c;
   logic [bb3_pkg::CNT_W-1:0] cnt0_d_ff, cnt1_d_ff;
   logic [NC-1:0][NCELL-1:0][CH-1:0] lane_cells;
   logic [NC-1:0][CH-1:0] mean0_e, mean1_e;
   bb3_pkg::flags_type flags_e;

   assign mask0_c = bb3_pkg::cell_mask(ctrl_c_ff.row_ok, ctrl_c_ff.col_ok0);
   assign mask1_c = bb3_pkg::cell_mask(ctrl_c_ff.row_ok, ctrl_c_ff.col_ok1);

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         for (int i = 0; i < WN; i++) begin
            for (int j = 0; j < WN; j++) begin
               lane_cells[k][i*WN + j] = win_ff[i][j][k*CH +: CH];
            end
         end
      end
   end

   for (genvar k = 0; k < NC; k++) begin : g_lane
      bb3_lane u_lane (
         .clock  (clock),
         .cells  (lane_cells[k]),
         .mask0  (mask0_c),
         .mask1  (mask1_c),
         .count0 (cnt0_d_ff),
         .count1 (cnt1_d_ff),
         .mean0  (mean0_e[k]),
         .mean1  (mean1_e[k])
      );
   end

   assign flags_e.emit0 = ctrl_e_ff.emit0;
   assign flags_e.emit1 = ctrl_e_ff.emit1;
   assign flags_e.fend0 = ctrl_e_ff.fend0;
   assign flags_e.last0 = ctrl_e_ff.last0;

   bb3_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (v_e_ff),
      .flags      (flags_e),
      .data0      (mean0_e),
      .data1      (mean1_e),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .accept_ok  (accept_ok)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WW'(RESET_W);
         height_ff   <= HW'(RESET_H);
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
         v_b_ff      <= 1'b0;
         v_c_ff      <= 1'b0;
         v_d_ff      <= 1'b0;
         v_e_ff      <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         draining_ff <= draining_in;
         v_b_ff      <= is_pix | is_fl;
         v_c_ff      <= v_b_ff;
         v_d_ff      <= v_c_ff;
         v_e_ff      <= v_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_b_ff  <= ctrl_a;
      addr_b_ff  <= rd_addr_a;
      px_b_ff    <= req_tdata;
      fwd_a_ff   <= fwd_a_in;
      fwd_b_ff   <= fwd_b_in;
      fwd_up_ff  <= mid_a;
      fwd_mid_ff <= px_b_ff;
      win_ff     <= win_in;
      ctrl_c_ff  <= ctrl_b_ff;
      ctrl_d_ff  <= ctrl_c_ff;
      ctrl_e_ff  <= ctrl_d_ff;
      cnt0_d_ff  <= bb3_pkg::mask_count(mask0_c);
      cnt1_d_ff  <= bb3_pkg::mask_count(mask1_c);
   end

endmodule

`default_nettype wire

// ===== rtl/bb3_ram.sv =====
// Generic simple RAM: one write port, two read ports with registered read data.
// No dependencies; a read at the address being written returns the old word.
`default_nettype none

module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/bb3_lane.sv =====
// One color channel of the blur: masked 3x3 sums for both results of an item,
// then the rounded mean by reciprocal multiply. Depends on bb3_pkg.
`default_nettype none

module bb3_lane (
   input  wire logic                                           clock,
   input  wire logic [bb3_pkg::CELLS-1:0][bb3_pkg::CH_W-1:0]   cells,
   input  wire logic [bb3_pkg::CELLS-1:0]                      mask0,
   input  wire logic [bb3_pkg::CELLS-1:0]                      mask1,
   input  wire logic [bb3_pkg::CNT_W-1:0]                      count0,
   input  wire logic [bb3_pkg::CNT_W-1:0]                      count1,
   output logic      [bb3_pkg::CH_W-1:0]                       mean0,
   output logic      [bb3_pkg::CH_W-1:0]                       mean1
);

   localparam int NUM_W  = bb3_pkg::SUM_W + 1;
   localparam int PROD_W = NUM_W + bb3_pkg::RECIP_W;

   logic [bb3_pkg::SUM_W-1:0] sum0_in, sum1_in, sum0_ff, sum1_ff;
   logic [bb3_pkg::CH_W-1:0]  mean0_in, mean1_in, mean0_ff, mean1_ff;

   // floor((2*sum + n) / (2*n)) as a multiply by the reciprocal of 2*n
   function automatic logic [bb3_pkg::CH_W-1:0] round_mean(
      input logic [bb3_pkg::SUM_W-1:0] s,
      input logic [bb3_pkg::CNT_W-1:0] n
   );
      logic [NUM_W-1:0]  num;
      logic [PROD_W-1:0] prod;
      num  = {s, 1'b0} + NUM_W'(n);
      prod = PROD_W'(num) * PROD_W'(bb3_pkg::recip_of(n));
      return prod[bb3_pkg::RECIP_W +: bb3_pkg::CH_W];
   endfunction

   always_comb begin
      sum0_in = '0;
      sum1_in = '0;
      for (int i = 0; i < bb3_pkg::CELLS; i++) begin
         if (mask0[i]) begin
            sum0_in = sum0_in + bb3_pkg::SUM_W'(cells[i]);
         end
         if (mask1[i]) begin
            sum1_in = sum1_in + bb3_pkg::SUM_W'(cells[i]);
         end
      end
   end

   assign mean0_in = round_mean(sum0_ff, count0);
   assign mean1_in = round_mean(sum1_ff, count1);

   always_ff @(posedge clock) begin
      sum0_ff  <= sum0_in;
      sum1_ff  <= sum1_in;
      mean0_ff <= mean0_in;
      mean1_ff <= mean1_in;
   end

   assign mean0 = mean0_ff;
   assign mean1 = mean1_ff;

endmodule

`default_nettype wire

// ===== rtl/bb3_merge.sv =====
// Merge stage: joins the lane means of an item into up to two result beats and
// queues them for the output channel. Depends on bb3_pkg.
`default_nettype none

module bb3_merge (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire bb3_pkg::flags_type        flags,
   input  wire logic [bb3_pkg::PIX_W-1:0] data0,
   input  wire logic [bb3_pkg::PIX_W-1:0] data1,
   input  wire logic                      rsp_tready,
   output logic                           rsp_tvalid,
   output logic      [bb3_pkg::PIX_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   output logic                           accept_ok
);

   localparam int AW = bb3_pkg::FIFO_AW;

   bb3_pkg::entry_type entry_ff [bb3_pkg::FIFO_DEPTH];
   bb3_pkg::entry_type res0, res1, head;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_1;
   logic [AW:0]   count_ff, count_in;
   logic          put0, put1, pop;
   logic [1:0]    push_n;

   assign put0   = push & flags.emit0;
   assign put1   = push & flags.emit1;
   assign push_n = {1'b0, put0} + {1'b0, put1};
   assign pop    = rsp_tvalid & rsp_tready;

   assign res0.frame_end = flags.fend0;
   assign res0.run_last  = flags.last0;
   assign res0.pixel     = data0;
   assign res1.frame_end = 1'b0;
   assign res1.run_last  = 1'b1;
   assign res1.pixel     = data1;

   // second result lands after the first when both are present
   assign wr_ptr_1  = put0 ? (wr_ptr_ff + AW'(1)) : wr_ptr_ff;
   assign wr_ptr_in = wr_ptr_ff + AW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + (AW+1)'(push_n) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put0) begin
         entry_ff[wr_ptr_ff] <= res0;
      end
      if (put1) begin
         entry_ff[wr_ptr_1] <= res1;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = head.pixel;
   assign rsp_tuser  = head.frame_end;
   assign rsp_tlast  = head.run_last;
   assign accept_ok  = (count_ff <= (AW+1)'(bb3_pkg::ACCEPT_LEVEL));

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for box_blur_3x3_edge_aware: streams RGB frames and flush beats, predicts
// each blurred pixel in its own model of the line stores and window, and checks results.
// Depends on rtl/bb3_pkg.sv and rtl/box_blur_3x3_edge_aware.sv.

module tb;
   import bb3_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 4096;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 110;
   localparam int TALL_ROWS     = 24;

   // indexes past the register list
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   // cell i*3+j is window row i, column j
   typedef rgb_type [8:0] patch_type;

   typedef struct packed {
      logic    kind;
      rgb_type color;
   } beat_type;

   typedef struct packed {
      rgb_type color;
      logic    frame_end;
      logic    run_last;
   } blur_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;    // in_red, in_green, in_blue
   logic                  req_tuser = KIND_PIXEL;  // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;         // out_red, out_green, out_blue
   logic                  rsp_tuser;         // frame_end
   logic                  rsp_tlast;         // run_last
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   box_blur_3x3_edge_aware dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // blur predictor state
   rgb_type   upper_row [MAX_W];
   rgb_type   middle_row [MAX_W];
   patch_type window_cells;
   int        width_px;
   int        height_rows;
   int        row_at;
   int        col_at;
   int        drain_at;
   bit        flushing;

   beat_type  pending_beats[$];
   blur_type  expected_blur[$];
   beat_type  next_beat;
   blur_type  want_blur;
   rgb_type   got_color;

   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   bit        req_taken = 1'b0;
   bit        hold_request = 1'b0;
   bit        rsp_hold = 1'b0;
   int        error_count = 0;
   int        cycle_count = 0;

   function automatic int dim_of(input int v, input int cap);
      if (v == 0) return 1;
      return (v > cap) ? cap : v;
   endfunction

   function automatic rgb_type random_color();
      rgb_type c;
      // lean on the channel extremes a quarter of the time
      c.red   = ($urandom_range(3) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom_range(255));
      c.green = ($urandom_range(3) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom_range(255));
      c.blue  = ($urandom_range(3) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom_range(255));
      return c;
   endfunction

   function automatic beat_type pixel_beat(input rgb_type c);
      beat_type b;
      b.kind  = KIND_PIXEL;
      b.color = c;
      return b;
   endfunction

   function automatic beat_type flush_beat();
      beat_type b;
      b.kind  = KIND_FLUSH;
      b.color = random_color();
      return b;
   endfunction

   // rounded-half-up mean over the cells whose row and column are inside the frame
   function automatic blur_type blur_mean(input patch_type cells, input logic [2:0] rows_ok,
                                          input logic [2:0] cols_ok, input logic fend,
                                          input logic last);
      int sum_r, sum_g, sum_b, count;
      blur_type res;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      count = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (rows_ok[i] && cols_ok[j]) begin
               sum_r += int'(cells[i*3+j].red);
               sum_g += int'(cells[i*3+j].green);
               sum_b += int'(cells[i*3+j].blue);
               count++;
            end
         end
      end
      res.color = '0;
      if (count != 0) begin
         res.color.red   = 8'((2 * sum_r + count) / (2 * count));
         res.color.green = 8'((2 * sum_g + count) / (2 * count));
         res.color.blue  = 8'((2 * sum_b + count) / (2 * count));
      end
      res.frame_end = fend;
      res.run_last  = last;
      return res;
   endfunction

   task automatic predict_beat(input beat_type b);
      patch_type  cells;
      logic [2:0] rows_ok;
      logic [2:0] cols_ok;
      rgb_type    above;
      rgb_type    mid;
      bit         row_end;
      int         c;
      if (b.kind == KIND_FLUSH) begin
         // drop flush beats while the frame is still open
         if (!flushing) return;
         for (int j = 0; j < 3; j++) begin
            c = drain_at + j;
            cols_ok[j] = (c >= 1) && (c - 1 < width_px);
            cells[j]   = upper_row[cols_ok[j] ? c - 1 : 0];
            cells[3+j] = middle_row[cols_ok[j] ? c - 1 : 0];
            cells[6+j] = '0;
         end
         rows_ok = {1'b0, 1'b1, height_rows >= 2};
         row_end = drain_at + 1 >= width_px;
         expected_blur.push_back(blur_mean(cells, rows_ok, cols_ok, row_end, 1'b1));
         if (row_end) begin
            flushing = 1'b0;
            drain_at = 0;
            row_at   = 0;
            col_at   = 0;
         end else begin
            drain_at++;
         end
      end else begin
         // drop pixels while the last row is pending
         if (flushing) return;
         above = upper_row[col_at];
         mid   = middle_row[col_at];
         upper_row[col_at]  = mid;
         middle_row[col_at] = b.color;
         for (int i = 0; i < 3; i++) begin
            window_cells[i*3]   = window_cells[i*3+1];
            window_cells[i*3+1] = window_cells[i*3+2];
         end
         window_cells[2] = above;
         window_cells[5] = mid;
         window_cells[8] = b.color;
         row_end = col_at + 1 >= width_px;
         rows_ok = {1'b1, 1'b1, row_at >= 2};
         if (row_at >= 1 && col_at >= 1) begin
            expected_blur.push_back(blur_mean(window_cells, rows_ok, {1'b1, 1'b1, col_at >= 2},
                                              1'b0, !row_end));
         end
         // right edge: shift the window once more with nothing coming in
         if (row_at >= 1 && row_end) begin
            for (int i = 0; i < 3; i++) begin
               cells[i*3]   = window_cells[i*3+1];
               cells[i*3+1] = window_cells[i*3+2];
               cells[i*3+2] = '0;
            end
            expected_blur.push_back(blur_mean(cells, rows_ok, {1'b0, 1'b1, col_at >= 1},
                                              1'b0, 1'b1));
         end
         if (row_end) begin
            col_at = 0;
            if (row_at + 1 >= height_rows) begin
               flushing = 1'b1;
               drain_at = 0;
               row_at   = 0;
            end else begin
               row_at++;
            end
         end else begin
            col_at++;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d want %0d", what, got, want));
   endtask

   // wait until nothing is queued, offered or expected, then let the pipeline settle
   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_tvalid || expected_blur.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      bit restarts;
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      restarts = 1'b1;
      case (index)
         CSR_FRAME_WIDTH:  width_px = dim_of(int'(value[WIDTH_FIELD_W-1:0]), MAX_W);
         CSR_FRAME_HEIGHT: height_rows = dim_of(int'(value[HEIGHT_FIELD_W-1:0]), MAX_H);
         default:          restarts = 1'b0;
      endcase
      if (restarts) begin
         row_at   = 0;
         col_at   = 0;
         drain_at = 0;
         flushing = 1'b0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one frame of w x h pixels and its flush beats, or only part of its pixels when cut_short, with a little noise
   task automatic queue_frame(input int w, input int h, input bit cut_short, output int queued);
      int stop_at;
      queued  = 0;
      stop_at = cut_short ? $urandom_range(w * h - 1) : w * h;
      for (int p = 0; p < stop_at; p++) begin
         if ($urandom_range(24) == 0) pending_beats.push_back(flush_beat());
         pending_beats.push_back(pixel_beat(random_color()));
         queued++;
         // stop queueing beats until every result is back
         if ($urandom_range(199) == 0) wait_drained();
      end
      if (cut_short) return;
      for (int d = 0; d < w; d++) begin
         pending_beats.push_back(flush_beat());
         queued++;
         if (d < w - 1 && $urandom_range(19) == 0)
            pending_beats.push_back(pixel_beat(random_color()));
      end
      if ($urandom_range(19) == 0) pending_beats.push_back(flush_beat());
   endtask

   task automatic random_frames(input int target);
      int made, queued, frames, which;
      logic [CSR_DATA_W-1:0] value;
      made = 0;
      while (made < target) begin
         which = $urandom_range(2);
         if (which != 1) begin
            value = ($urandom_range(15) == 0) ? '0 : 13'($urandom_range(1, 14));
            value[12:11] = 2'($urandom_range(3));   // above the width field
            write_csr(CSR_FRAME_WIDTH, value);
         end
         if (which != 0) begin
            value = ($urandom_range(15) == 0) ? '0 : 13'($urandom_range(1, 10));
            write_csr(CSR_FRAME_HEIGHT, value);
         end
         if ($urandom_range(9) == 0)
            write_csr(($urandom_range(1) == 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      13'($urandom_range(8191)));
         frames = $urandom_range(1, 3);
         for (int k = 0; k < frames; k++) begin
            queue_frame(width_px, height_rows, k == frames - 1 && $urandom_range(9) == 0,
                        queued);
            made += queued;
         end
      end
   endtask

   // sender: present the next queued beat once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_beat.kind;
               req_tdata  <= next_beat.color;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver stall so the result queue fills and the input backs up
   initial begin
      wait (hold_request);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blur.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want_blur = expected_blur.pop_front();
               got_color = rgb_type'(rsp_tdata);
               check_field("out_red", got_color.red, want_blur.color.red);
               check_field("out_green", got_color.green, want_blur.color.green);
               check_field("out_blue", got_color.blue, want_blur.color.blue);
               check_field("frame_end", rsp_tuser, want_blur.frame_end);
               check_field("run_last", rsp_tlast, want_blur.run_last);
            end
         end
         if (req_tvalid && req_tready) predict_beat(beat_type'({req_tuser, req_tdata}));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int queued;
      rgb_type c;
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      window_cells = '0;
      width_px     = RESET_DIM;
      height_rows  = RESET_DIM;
      row_at       = 0;
      col_at       = 0;
      drain_at     = 0;
      flushing     = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 19;
      recv_idle_pct = 73;

      // 3x3 frame: corners, edges and center, with a stray flush before it and a stray pixel among its flush beats
      write_csr(CSR_FRAME_WIDTH, 13'd3);
      write_csr(CSR_FRAME_HEIGHT, 13'd3);
      pending_beats.push_back(flush_beat());
      for (int p = 0; p < 9; p++) begin
         c.red   = (p % 2 == 1) ? 8'hFF : 8'h00;
         c.green = (p % 3 == 0) ? 8'hFF : 8'h00;
         c.blue  = 8'(p * 37);
         pending_beats.push_back(pixel_beat(c));
      end
      pending_beats.push_back(flush_beat());
      pending_beats.push_back(pixel_beat(random_color()));
      pending_beats.push_back(flush_beat());
      pending_beats.push_back(flush_beat());

      // 2x2 frame with a write to an unmapped index in the middle; it must not restart
      write_csr(CSR_FRAME_WIDTH, 13'd2);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      pending_beats.push_back(pixel_beat(24'hFFFFFF));
      pending_beats.push_back(pixel_beat(24'h000000));
      write_csr(CSR_SPARE_A, '1);
      pending_beats.push_back(pixel_beat(24'hFFFFFF));
      pending_beats.push_back(pixel_beat(24'h010203));
      pending_beats.push_back(flush_beat());
      pending_beats.push_back(flush_beat());

      // abandon a frame part way, then a single-pixel frame
      for (int p = 0; p < 3; p++) pending_beats.push_back(pixel_beat(random_color()));
      write_csr(CSR_FRAME_WIDTH, 13'd1);
      write_csr(CSR_FRAME_HEIGHT, 13'd1);
      pending_beats.push_back(pixel_beat(24'h80FF7F));
      pending_beats.push_back(flush_beat());

      random_frames(RANDOM_ITEMS);

      wait_drained();
      send_idle_pct = 73;
      recv_idle_pct = 19;
      random_frames(RANDOM_ITEMS);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_FRAME_WIDTH, 13'd16);
      write_csr(CSR_FRAME_HEIGHT, 13'd12);
      hold_request = 1'b1;
      queue_frame(width_px, height_rows, 1'b0, queued);
      random_frames(RANDOM_ITEMS);

      // widest rows (width field saturates): one full row and the start of the next
      write_csr(CSR_FRAME_WIDTH, 13'h07FF);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      for (int p = 0; p < MAX_W + 4; p++) pending_beats.push_back(pixel_beat(random_color()));
      // tallest frame one pixel wide (height field saturates); leave it after a few rows
      write_csr(CSR_FRAME_WIDTH, 13'd0);
      write_csr(CSR_FRAME_HEIGHT, 13'h1FFF);
      for (int p = 0; p < TALL_ROWS; p++) pending_beats.push_back(pixel_beat(random_color()));

      wait_drained();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
